// ----- rtl/tremc_pkg.sv -----
// Shared types and constants for the toy register machine execute core.
// Holds the action and operand-kind codes and the decoded word format.
// No dependencies; every other file of the core imports it.
`default_nettype none

package tremc_pkg;

   // Default sizes of the machine state.
   localparam int DEF_MEM_WORDS = 64;
   localparam int DEF_NUM_REGS  = 5;

   // Fixed field widths of the instruction and result words.
   localparam int ACTION_W    = 3;
   localparam int INDEX_W     = 6;
   localparam int SKIND_W     = 2;
   localparam int VALUE_W     = 31;
   localparam int DATA_W      = 32;
   localparam int BYTE_W      = 8;
   // Register index field covers up to eight registers, memory field 64 bytes.
   localparam int REG_FIELD_W = 3;
   localparam int MEM_FIELD_W = 6;

   typedef enum logic [ACTION_W-1:0] {
      ACT_MOV    = 3'd0,
      ACT_ADD    = 3'd1,
      ACT_SUB    = 3'd2,
      ACT_JMP    = 3'd3,
      ACT_JPN    = 3'd4,
      ACT_PRN    = 3'd5,
      ACT_HLT    = 3'd6,
      ACT_UNUSED = 3'd7
   } action_type;

   typedef enum logic {
      FK_REG = 1'b0,
      FK_MEM = 1'b1
   } first_kind_type;

   typedef enum logic [SKIND_W-1:0] {
      SK_REG   = 2'd0,
      SK_MEM   = 2'd1,
      SK_CONST = 2'd2,
      SK_NONE  = 2'd3
   } second_kind_type;

   // Operation classes handed from the front end to the back end.
   typedef enum logic [3:0] {
      OP_ERR    = 4'd0,
      OP_HALT   = 4'd1,
      OP_MOV_RR = 4'd2,
      OP_MOV_RM = 4'd3,
      OP_MOV_RC = 4'd4,
      OP_MOV_MR = 4'd5,
      OP_MOV_MC = 4'd6,
      OP_ADD    = 4'd7,
      OP_SUB    = 4'd8,
      OP_JUMP   = 4'd9,
      OP_JZ     = 4'd10,
      OP_JN     = 4'd11,
      OP_PRINT  = 4'd12
   } op_type;

   // Where the source operand of ADD, SUB and PRN comes from.
   typedef enum logic [1:0] {
      SRC_REG   = 2'd0,
      SRC_MEM   = 2'd1,
      SRC_CONST = 2'd2
   } src_type;

   // Decoded word: all index checks are already done when it is built.
   typedef struct packed {
      op_type                 op;
      src_type                src;
      logic [REG_FIELD_W-1:0] ra;     // first register read port
      logic [REG_FIELD_W-1:0] rb;     // second register read port
      logic [REG_FIELD_W-1:0] rw;     // register write destination
      logic [MEM_FIELD_W-1:0] maddr;  // memory read or write address
      logic [VALUE_W-1:0]     cval;   // constant or jump target
   } uop_type;

endpackage

`default_nettype wire

// ----- rtl/tremc_front.sv -----
// Front end of the execute core: checks and classifies one instruction word.
// Depends on tremc_pkg for the code and decoded word types.
`default_nettype none

module tremc_front #(
   parameter int NUM_REGS  = tremc_pkg::DEF_NUM_REGS,
   parameter int MEM_WORDS = tremc_pkg::DEF_MEM_WORDS
) (
   input  wire logic [tremc_pkg::ACTION_W-1:0] action,
   input  wire logic                           first_kind,
   input  wire logic [tremc_pkg::INDEX_W-1:0]  first_index,
   input  wire logic [tremc_pkg::SKIND_W-1:0]  second_kind,
   input  wire logic [tremc_pkg::VALUE_W-1:0]  second_value,
   output tremc_pkg::uop_type                  uop
);
   import tremc_pkg::*;

   action_type      act;
   first_kind_type  fk;
   second_kind_type sk;
   logic            fi_reg_ok;
   logic            fi_mem_ok;
   logic            sv_reg_ok;
   logic            sv_mem_ok;
   logic            src_ok;

   assign act = action_type'(action);
   assign fk  = first_kind_type'(first_kind);
   assign sk  = second_kind_type'(second_kind);

   // Range checks depend on the word alone, so they are done here.
   assign fi_reg_ok = ({1'b0, first_index} < (INDEX_W + 1)'(NUM_REGS));
   assign fi_mem_ok = ({1'b0, first_index} < (INDEX_W + 1)'(MEM_WORDS));
   assign sv_reg_ok = ({1'b0, second_value} < DATA_W'(NUM_REGS));
   assign sv_mem_ok = ({1'b0, second_value} < DATA_W'(MEM_WORDS));

   // A source operand is usable when its kind is present and its index fits.
   always_comb begin
      unique case (sk)
         SK_REG:   src_ok = sv_reg_ok;
         SK_MEM:   src_ok = sv_mem_ok;
         SK_CONST: src_ok = 1'b1;
         SK_NONE:  src_ok = 1'b0;
      endcase
   end

   // Classify the word into one operation class.
   always_comb begin
      uop.op    = OP_ERR;
      uop.ra    = first_index[REG_FIELD_W-1:0];
      uop.rb    = second_value[REG_FIELD_W-1:0];
      uop.rw    = first_index[REG_FIELD_W-1:0];
      uop.maddr = (sk == SK_MEM) ? second_value[MEM_FIELD_W-1:0] : first_index;
      uop.cval  = second_value;
      unique case (sk)
         SK_REG:  uop.src = SRC_REG;
         SK_MEM:  uop.src = SRC_MEM;
         default: uop.src = SRC_CONST;
      endcase

      unique case (act)
         ACT_MOV: begin
            if (fk == FK_REG) begin
               if (fi_reg_ok) begin
                  unique case (sk)
                     SK_REG: begin
                        if (sv_reg_ok) begin
                           uop.op = OP_MOV_RR;
                           uop.rw = second_value[REG_FIELD_W-1:0];
                        end
                     end
                     SK_MEM:   uop.op = sv_mem_ok ? OP_MOV_RM : OP_ERR;
                     SK_CONST: uop.op = OP_MOV_RC;
                     SK_NONE:  uop.op = OP_ERR;
                  endcase
               end
            end else if (fi_mem_ok) begin
               unique case (sk)
                  SK_REG: begin
                     if (sv_reg_ok) begin
                        uop.op = OP_MOV_MR;
                        uop.rw = second_value[REG_FIELD_W-1:0];
                     end
                  end
                  SK_CONST: uop.op = OP_MOV_MC;
                  default:  uop.op = OP_ERR;
               endcase
            end
         end
         ACT_ADD, ACT_SUB: begin
            if (fk == FK_REG && fi_reg_ok && src_ok) begin
               uop.op = (act == ACT_ADD) ? OP_ADD : OP_SUB;
            end
         end
         ACT_JMP, ACT_JPN: begin
            if (sk == SK_NONE) begin
               uop.op = (act == ACT_JMP) ? OP_JUMP : OP_ERR;
            end else if (sk == SK_CONST && fk == FK_REG && fi_reg_ok) begin
               uop.op = (act == ACT_JMP) ? OP_JZ : OP_JN;
            end
         end
         ACT_PRN:    uop.op = src_ok ? OP_PRINT : OP_ERR;
         ACT_HLT:    uop.op = OP_HALT;
         ACT_UNUSED: uop.op = OP_ERR;
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/tremc_queue.sv -----
// Two-entry queue of decoded words between the front and back ends.
// Depends on tremc_pkg for the decoded word type.
`default_nettype none

module tremc_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push_valid,
   output logic                    push_ready,
   input  wire tremc_pkg::uop_type push_data,
   output logic                    pop_valid,
   input  wire logic               pop_ready,
   output tremc_pkg::uop_type      pop_data
);
   import tremc_pkg::*;

   localparam logic [1:0] FULL_COUNT = 2'd2;

   uop_type    slot_ff [2];
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic       do_push;
   logic       do_pop;

   assign push_ready = (count_ff != FULL_COUNT);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Occupancy follows pushes and pops.
   always_comb begin
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (do_push) wr_ptr_ff <= ~wr_ptr_ff;
         if (do_pop)  rd_ptr_ff <= ~rd_ptr_ff;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_data;
   end

endmodule

`default_nettype wire

// ----- rtl/tremc_back.sv -----
// Back end of the execute core: operand read stage, execute and result register.
// Holds the register file, byte memory and halt flag. Depends on tremc_pkg.
`default_nettype none

module tremc_back #(
   parameter int NUM_REGS  = tremc_pkg::DEF_NUM_REGS,
   parameter int MEM_WORDS = tremc_pkg::DEF_MEM_WORDS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          pop_valid,
   output logic                               pop_ready,
   input  wire tremc_pkg::uop_type            pop_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_print_valid,
   output logic signed [tremc_pkg::DATA_W-1:0] rsp_print_value,
   output logic                               rsp_jump_taken,
   output logic [tremc_pkg::VALUE_W-1:0]      rsp_jump_target,
   output logic                               rsp_halted,
   output logic                               rsp_error
);
   import tremc_pkg::*;

   localparam int RIW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
   localparam int MAW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

   // Architectural state.
   logic [DATA_W-1:0]  regs_ff [NUM_REGS];
   logic [BYTE_W-1:0]  mem_array [MEM_WORDS];
   logic [MEM_WORDS-1:0] mem_vld_ff;
   logic               halt_flag_ff;

   // Read stage registers.
   logic               b_valid_ff;
   uop_type            b_uop_ff;
   logic [DATA_W-1:0]  b_a_ff;
   logic [DATA_W-1:0]  b_b_ff;
   logic [BYTE_W-1:0]  b_raw_ff;
   logic               b_vld_ff;
   logic               b_fwd_ff;
   logic [BYTE_W-1:0]  b_fwd_byte_ff;

   // Result register.
   logic               rsp_valid_ff;
   logic               rsp_pv_ff;
   logic [DATA_W-1:0]  rsp_pval_ff;
   logic               rsp_jt_ff;
   logic [VALUE_W-1:0] rsp_target_ff;
   logic               rsp_halted_ff;
   logic               rsp_err_ff;

   logic               commit;
   logic               b_load;
   logic [RIW-1:0]     pop_ra;
   logic [RIW-1:0]     pop_rb;
   logic [MAW-1:0]     pop_ma;
   logic [DATA_W-1:0]  a_in;
   logic [DATA_W-1:0]  b_in;
   logic               fwd_in;
   logic [BYTE_W-1:0]  mem_byte;
   logic [DATA_W-1:0]  src_val;

   logic               wreg_en;
   logic [RIW-1:0]     wreg_idx;
   logic [DATA_W-1:0]  wreg_val;
   logic               wmem_en;
   logic [MAW-1:0]     wmem_addr;
   logic [BYTE_W-1:0]  wmem_byte;
   logic               pv_in;
   logic [DATA_W-1:0]  pval_in;
   logic               jt_in;
   logic               err_in;
   logic               halt_in;

   // Stage handshakes: execute when the result register is free or draining.
   assign commit    = b_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign pop_ready = !b_valid_ff || commit;
   assign b_load    = pop_valid && pop_ready;

   assign pop_ra = pop_data.ra[RIW-1:0];
   assign pop_rb = pop_data.rb[RIW-1:0];
   assign pop_ma = pop_data.maddr[MAW-1:0];

   // Register reads see the write of the word that executes in the same cycle.
   assign a_in   = (wreg_en && wreg_idx == pop_ra) ? wreg_val : regs_ff[pop_ra];
   assign b_in   = (wreg_en && wreg_idx == pop_rb) ? wreg_val : regs_ff[pop_rb];
   assign fwd_in = wmem_en && (wmem_addr == pop_ma);

   // Never-written bytes read as zero; a same-cycle store is forwarded.
   assign mem_byte = b_fwd_ff ? b_fwd_byte_ff : (b_vld_ff ? b_raw_ff : '0);

   // Source operand of ADD, SUB and PRN.
   always_comb begin
      unique case (b_uop_ff.src)
         SRC_REG:   src_val = b_b_ff;
         SRC_MEM:   src_val = {{(DATA_W - BYTE_W){1'b0}}, mem_byte};
         SRC_CONST: src_val = {1'b0, b_uop_ff.cval};
         default:   src_val = '0;
      endcase
   end

   // Execute the word in the read stage.
   always_comb begin
      wreg_en   = 1'b0;
      wreg_idx  = b_uop_ff.rw[RIW-1:0];
      wreg_val  = b_a_ff;
      wmem_en   = 1'b0;
      wmem_addr = b_uop_ff.maddr[MAW-1:0];
      wmem_byte = b_a_ff[BYTE_W-1:0];
      pv_in     = 1'b0;
      pval_in   = '0;
      jt_in     = 1'b0;
      err_in    = 1'b0;
      halt_in   = 1'b0;
      if (!halt_flag_ff) begin
         unique case (b_uop_ff.op)
            OP_MOV_RR: wreg_en = 1'b1;
            OP_MOV_RM: wmem_en = 1'b1;
            OP_MOV_RC: begin
               wreg_en  = 1'b1;
               wreg_val = {1'b0, b_uop_ff.cval};
            end
            OP_MOV_MR: begin
               wreg_en  = 1'b1;
               wreg_val = {{(DATA_W - BYTE_W){1'b0}}, mem_byte};
            end
            OP_MOV_MC: begin
               wmem_en   = 1'b1;
               wmem_byte = b_uop_ff.cval[BYTE_W-1:0];
            end
            OP_ADD: begin
               wreg_en  = 1'b1;
               wreg_val = b_a_ff + src_val;
            end
            OP_SUB: begin
               wreg_en  = 1'b1;
               wreg_val = b_a_ff - src_val;
            end
            OP_JUMP: jt_in = 1'b1;
            OP_JZ:   jt_in = (b_a_ff == '0);
            OP_JN:   jt_in = (b_a_ff == '0) || b_a_ff[DATA_W-1];
            OP_PRINT: begin
               pv_in   = 1'b1;
               pval_in = src_val;
            end
            OP_HALT: halt_in = 1'b1;
            default: err_in = 1'b1;
         endcase
      end
      wreg_en = wreg_en && commit;
      wmem_en = wmem_en && commit;
   end

   // Control state of the back end.
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         halt_flag_ff <= 1'b0;
         mem_vld_ff   <= '0;
      end else begin
         if (pop_ready)  b_valid_ff <= pop_valid;
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (commit && halt_in) halt_flag_ff <= 1'b1;
         if (wmem_en) mem_vld_ff[wmem_addr] <= 1'b1;
      end
   end

   // Register file, cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) regs_ff[i] <= '0;
      end else if (wreg_en) begin
         regs_ff[wreg_idx] <= wreg_val;
      end
   end

   // Byte memory write port.
   always_ff @(posedge clock) begin
      if (wmem_en) mem_array[wmem_addr] <= wmem_byte;
   end

   // Operand read stage, including the registered memory read.
   always_ff @(posedge clock) begin
      if (b_load) begin
         b_uop_ff      <= pop_data;
         b_a_ff        <= a_in;
         b_b_ff        <= b_in;
         b_raw_ff      <= mem_array[pop_ma];
         b_vld_ff      <= mem_vld_ff[pop_ma];
         b_fwd_ff      <= fwd_in;
         b_fwd_byte_ff <= wmem_byte;
      end
   end

   // Result word payload.
   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_pv_ff     <= pv_in;
         rsp_pval_ff   <= pval_in;
         rsp_jt_ff     <= jt_in;
         rsp_target_ff <= jt_in ? b_uop_ff.cval : '0;
         rsp_halted_ff <= halt_flag_ff || halt_in;
         rsp_err_ff    <= err_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_print_valid = rsp_pv_ff;
   assign rsp_print_value = rsp_pval_ff;
   assign rsp_jump_taken  = rsp_jt_ff;
   assign rsp_jump_target = rsp_target_ff;
   assign rsp_halted      = rsp_halted_ff;
   assign rsp_error       = rsp_err_ff;

endmodule

`default_nettype wire

// ----- rtl/toy_register_machine_execute_core.sv -----
// Top level of the toy register machine execute core.
// Instantiates tremc_front, tremc_queue and tremc_back; depends on tremc_pkg.
//
//   Port group  Direction  Handshake              Word
//   req_*       in         req_valid / req_ready  one instruction word
//   rsp_*       out        rsp_valid / rsp_ready  one result per instruction
//
// One instruction is accepted per cycle when nothing stalls.
// An accepted instruction passes through the queue, then operand read, then
// execute into the result register.
// The operand read stage forwards the write of the instruction executing next to it.
// A stalled result holds the back end; the queue then fills and req_ready drops.
// Synchronous reset clears the registers, the memory valid bits and the halt flag.
`default_nettype none

module toy_register_machine_execute_core #(
   parameter int NUM_REGS  = tremc_pkg::DEF_NUM_REGS,
   parameter int MEM_WORDS = tremc_pkg::DEF_MEM_WORDS
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [tremc_pkg::ACTION_W-1:0] req_action,
   input  wire logic                           req_first_kind,
   input  wire logic [tremc_pkg::INDEX_W-1:0]  req_first_index,
   input  wire logic [tremc_pkg::SKIND_W-1:0]  req_second_kind,
   input  wire logic [tremc_pkg::VALUE_W-1:0]  req_second_value,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic                                rsp_print_valid,
   output logic signed [tremc_pkg::DATA_W-1:0] rsp_print_value,
   output logic                                rsp_jump_taken,
   output logic [tremc_pkg::VALUE_W-1:0]       rsp_jump_target,
   output logic                                rsp_halted,
   output logic                                rsp_error
);
   import tremc_pkg::*;

   uop_type front_uop;
   uop_type queue_uop;
   logic    queue_valid;
   logic    queue_ready;

   // Classify the incoming word.
   tremc_front #(
      .NUM_REGS  (NUM_REGS),
      .MEM_WORDS (MEM_WORDS)
   ) u_front (
      .action       (req_action),
      .first_kind   (req_first_kind),
      .first_index  (req_first_index),
      .second_kind  (req_second_kind),
      .second_value (req_second_value),
      .uop          (front_uop)
   );

   // Decouple the front end from the back end.
   tremc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_ready (req_ready),
      .push_data  (front_uop),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_data   (queue_uop)
   );

   // Read operands, execute and hold the result.
   tremc_back #(
      .NUM_REGS  (NUM_REGS),
      .MEM_WORDS (MEM_WORDS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (queue_valid),
      .pop_ready       (queue_ready),
      .pop_data        (queue_uop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_print_valid (rsp_print_valid),
      .rsp_print_value (rsp_print_value),
      .rsp_jump_taken  (rsp_jump_taken),
      .rsp_jump_target (rsp_jump_target),
      .rsp_halted      (rsp_halted),
      .rsp_error       (rsp_error)
   );

   // A halted result carries no print, jump or error.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_halted |-> !rsp_print_valid && !rsp_jump_taken && !rsp_error)
      else $error("halted result carries other flags");

   // At most one of print, jump and error in a result.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $countones({rsp_print_valid, rsp_jump_taken, rsp_error}) <= 1)
      else $error("result has more than one outcome");

   // The queue only fills up while a result waits downstream.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("queue full without a pending result");

   // A jump target is reported only with a taken jump.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_jump_taken |-> rsp_jump_target == '0)
      else $error("jump target without taken jump");

endmodule

`default_nettype wire
